### design/batch_bubble_sorter_core_macros.svh
// assertion macros for the batch bubble sorter core
// expects signals named clock and reset in the module that uses them
`ifndef BATCH_BUBBLE_SORTER_CORE_MACROS_SVH
`define BATCH_BUBBLE_SORTER_CORE_MACROS_SVH

// consequent in the same cycle
`define BBS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the next cycle
`define BBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bbs_pkg.sv
// shared types and constants of the batch bubble sorter core
// no dependencies
package bbs_pkg;

   localparam int VALUE_W       = 32;
   localparam int MAX_ITEMS_DEF = 32;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic                      last_res;
      logic                      dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_PASS_RD,
      ST_PASS_HOLD,
      ST_CMP_RD,
      ST_CMP,
      ST_PASS_END,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   typedef struct packed {
      logic ready;
      logic load;
      logic init;
      logic pass_rd;
      logic pass_hold;
      logic cmp_rd;
      logic cmp;
      logic pass_end;
      logic out_rd;
      logic out_ld;
   } dp_cmd_type;

   typedef struct packed {
      logic count_lt2;
      logic j_at_limit;
      logic limit_is_one;
      logic k_at_end;
      logic rsp_busy;
   } dp_status_type;

endpackage

### design/bbs_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bbs_datapath.sv
// datapath of the batch bubble sorter: element store, counters, compare, output register
// depends on bbs_pkg, bbs_ram and batch_bubble_sorter_core_macros.svh
`include "batch_bubble_sorter_core_macros.svh"

module bbs_datapath import bbs_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  req_type       req_payload,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_payload
);

   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);

   logic [CW-1:0]      count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      limit_ff, limit_in;
   logic [AW-1:0]      k_ff, k_in;
   logic [VALUE_W-1:0] held_ff, held_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data;

   logic full, swap, k_at_end;

   assign full     = (count_ff == CW'(MAX_ITEMS));
   assign swap     = ($signed(rd_data) < $signed(held_ff));
   assign k_at_end = (k_ff == AW'(count_ff - 1'b1));

   bbs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(MAX_ITEMS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_payload.value;
      if (cmd.load && !full) begin
         wr_en = 1'b1;
      end else if (cmd.cmp) begin
         wr_en   = 1'b1;
         wr_addr = j_ff - 1'b1;
         wr_data = swap ? rd_data : held_ff;
      end else if (cmd.pass_end) begin
         wr_en   = 1'b1;
         wr_addr = limit_ff;
         wr_data = held_ff;
      end
   end

   always_comb begin
      rd_en = cmd.pass_rd | cmd.cmp_rd | cmd.out_rd;
      if (cmd.pass_rd) begin
         rd_addr = '0;
      end else if (cmd.cmp_rd) begin
         rd_addr = j_ff;
      end else begin
         rd_addr = k_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      j_in         = j_ff;
      limit_in     = limit_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.init) begin
         limit_in = AW'(count_ff - 1'b1);
         k_in     = '0;
      end
      if (cmd.pass_hold) begin
         held_in = rd_data;
         j_in    = AW'(1);
      end
      if (cmd.cmp) begin
         held_in = swap ? held_ff : rd_data;
         j_in    = j_ff + 1'b1;
      end
      if (cmd.pass_end) begin
         limit_in = limit_ff - 1'b1;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_ld) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.value_res = rd_data;
         rsp_data_in.last_res  = k_at_end;
         rsp_data_in.dropped   = ovf_ff;
         k_in                  = k_ff + 1'b1;
         if (k_at_end) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      limit_ff    <= limit_in;
      k_ff        <= k_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.count_lt2    = (count_ff < CW'(2));
   assign status.j_at_limit   = (j_ff == limit_ff);
   assign status.limit_is_one = (limit_ff == AW'(1));
   assign status.k_at_end     = k_at_end;
   assign status.rsp_busy     = rsp_valid_ff & rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `BBS_ASSERT_SAME(a_count_range, 1'b1, count_ff <= CW'(MAX_ITEMS), "count beyond capacity")
   `BBS_ASSERT_SAME(a_load_free, cmd.out_ld, !rsp_valid_ff, "output register overwritten")
   `BBS_ASSERT_NEXT(a_load_shows, cmd.out_ld, rsp_valid_ff, "loaded result not presented")

endmodule

### design/bbs_controller.sv
// controller state machine of the batch bubble sorter: load, sort passes, drain
// depends on bbs_pkg
module bbs_controller import bbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_last,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = status.count_lt2 ? ST_OUT_RD : ST_PASS_RD;
         end
         ST_PASS_RD:   state_in = ST_PASS_HOLD;
         ST_PASS_HOLD: state_in = ST_CMP_RD;
         ST_CMP_RD:    state_in = ST_CMP;
         ST_CMP: begin
            state_in = status.j_at_limit ? ST_PASS_END : ST_CMP_RD;
         end
         ST_PASS_END: begin
            state_in = status.limit_is_one ? ST_OUT_RD : ST_PASS_RD;
         end
         ST_OUT_RD: begin
            if (!status.rsp_busy) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            state_in = status.k_at_end ? ST_LOAD : ST_OUT_RD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_INIT:      cmd.init      = 1'b1;
         ST_PASS_RD:   cmd.pass_rd   = 1'b1;
         ST_PASS_HOLD: cmd.pass_hold = 1'b1;
         ST_CMP_RD:    cmd.cmp_rd    = 1'b1;
         ST_CMP:       cmd.cmp       = 1'b1;
         ST_PASS_END:  cmd.pass_end  = 1'b1;
         ST_OUT_RD:    cmd.out_rd    = !status.rsp_busy;
         ST_OUT_LD:    cmd.out_ld    = 1'b1;
         default:      cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/batch_bubble_sorter_core.sv
// top level of the batch bubble sorter: controller plus datapath
// depends on bbs_pkg, bbs_controller, bbs_datapath
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_type (value, last)
//   rsp       out         rsp_valid / rsp_stall  rsp_type (value_res, last_res, dropped)
//
// loading accepts one element per cycle; the element marked last closes the batch
// each sort pass on the store's ram port moves the largest value left to the end of the pass
// draining reads each result, then loads it; reads wait while the result side stalls
// req_stall stays high from batch close until the final result sits in the output register
// reset clears the element count, the drop flag and the output valid; no clearing pass
module batch_bubble_sorter_core import bbs_pkg::*; #(
   parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bbs_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_last (req_payload.last),
      .status   (status),
      .cmd      (cmd)
   );

   bbs_datapath #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_payload(req_payload),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   assign req_stall = ~cmd.ready;

endmodule

### dv/testbench.sv
// testbench for batch_bubble_sorter_core: sends batches of signed values, predicts the
// sorted output with a local bubble sort and checks every result transaction
// depends on bbs_pkg and batch_bubble_sorter_core
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bbs_pkg::*;

   localparam int CAPACITY       = MAX_ITEMS_DEF;
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int PRINT_LIMIT    = 100;
   localparam int MOST_NEG       = 32'sh8000_0000;
   localparam int MOST_POS       = 32'sh7fff_ffff;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int error_count   = 0;
   int quiet_cycles  = 0;

   logic signed [VALUE_W-1:0] batch_values [CAPACITY];
   int      batch_count = 0;
   bit      batch_lost  = 1'b0;
   rsp_type sorted_results_q [$];

   batch_bubble_sorter_core #(
      .MAX_ITEMS(CAPACITY)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
   endtask

   // store one element of the open batch; on close, sort and queue the results
   function automatic void absorb_element(input req_type item);
      rsp_type                   res;
      logic signed [VALUE_W-1:0] tmp;
      if (batch_count < CAPACITY) begin
         batch_values[batch_count] = item.value;
         batch_count++;
      end else begin
         batch_lost = 1'b1;
      end
      if (item.last) begin
         for (int pass = 0; pass + 1 < batch_count; pass++) begin
            for (int j = 0; j + 1 < batch_count - pass; j++) begin
               if (batch_values[j] > batch_values[j+1]) begin
                  tmp               = batch_values[j];
                  batch_values[j]   = batch_values[j+1];
                  batch_values[j+1] = tmp;
               end
            end
         end
         for (int k = 0; k < batch_count; k++) begin
            res.value_res = batch_values[k];
            res.last_res  = (k == batch_count - 1);
            res.dropped   = batch_lost;
            sorted_results_q.push_back(res);
         end
         batch_count = 0;
         batch_lost  = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d last %b dropped %b",
               rsp_payload.value_res, rsp_payload.last_res, rsp_payload.dropped));
         end else begin
            want = sorted_results_q.pop_front();
            if (rsp_payload.value_res !== want.value_res ||
                rsp_payload.last_res !== want.last_res ||
                rsp_payload.dropped !== want.dropped) begin
               report_mismatch($sformatf(
                  "got value %0d last %b dropped %b, expected value %0d last %b dropped %b",
                  rsp_payload.value_res, rsp_payload.last_res, rsp_payload.dropped,
                  want.value_res, want.last_res, want.dropped));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called and returns at a falling edge; valid stays up for a following transaction
   task automatic send_element(input int value, input logic is_last);
      req_type item;
      item.value = value;
      item.last  = is_last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_element(item);
      @(negedge clock);
   endtask

   task automatic send_batch(input int values [$]);
      for (int i = 0; i < values.size(); i++) begin
         send_element(values[i], i == values.size() - 1);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sorted_results_q.size() != 0) @(negedge clock);
   endtask

   function automatic int pick_value(input int mode);
      case (mode)
         0: return $urandom;
         1: return int'($urandom_range(8)) - 4;
         2: begin
            case ($urandom_range(3))
               0: return MOST_NEG;
               1: return MOST_POS;
               2: return MOST_NEG + int'($urandom_range(3));
               default: return MOST_POS - int'($urandom_range(3));
            endcase
         end
         default: return pick_value($urandom_range(2));
      endcase
   endfunction

   task automatic test_single_element();
      send_batch({-7});
      send_batch({MOST_NEG});
   endtask

   task automatic test_extreme_values();
      send_batch({MOST_POS, MOST_NEG, 0, -1, 1, MOST_POS - 1, MOST_NEG + 1});
   endtask

   task automatic test_equal_values();
      send_batch({3, -3, 3, 3, -3, 0});
      send_batch({-2, -1, 0, 1});
   endtask

   // exactly full, then the closing transaction dropped, then several dropped
   task automatic test_full_and_overflow();
      int sizes [3] = '{CAPACITY, CAPACITY + 1, CAPACITY + 8};
      foreach (sizes[s]) begin
         for (int i = 0; i < sizes[s]; i++) begin
            send_element(pick_value(3), i == sizes[s] - 1);
         end
      end
   endtask

   task automatic test_random_batches(input int target);
      int sent;
      int size;
      int mode;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(14) == 0) size = $urandom_range(CAPACITY - 4, CAPACITY + 8);
         else size = $urandom_range(1, 12);
         mode = $urandom_range(3);
         for (int i = 0; i < size; i++) begin
            send_element(pick_value(mode), i == size - 1);
         end
         sent += size;
      end
   endtask

   initial begin
      send_idle_pct = 19;
      recv_idle_pct = 71;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_element();
      test_extreme_values();
      test_equal_values();
      test_full_and_overflow();
      wait_for_results();
      test_random_batches(110);
      wait_for_results();
      send_idle_pct = 71;
      recv_idle_pct = 19;
      test_random_batches(110);
      wait_for_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_batches(110);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
